/* rtl/core/greedy_rectangle_merge_core_assert.svh */
// Assertion macros for the rectangle merge core.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef GREEDY_RECTANGLE_MERGE_CORE_ASSERT_SVH
`define GREEDY_RECTANGLE_MERGE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define GRM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
`define GRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define GRM_ASSERT(lbl, prop)
`define GRM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/grm_pkg.sv */
package grm_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  // payload field widths
  localparam int POS_W = 6;
  localparam int DIM_W = 7;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // cell encoding: bit0 solid, bit1 covered
  localparam int CELL_W = 2;
  localparam logic [CELL_W-1:0] CELL_FREE  = 2'b01;
  localparam logic [CELL_W-1:0] CELL_TAKEN = 2'b11;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] GRID_RESET = 7'd64;

  typedef struct packed {
    logic             action;
    logic [POS_W-1:0] cell_x;
    logic [POS_W-1:0] cell_y;
    logic             solid;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] rect_x;
    logic [POS_W-1:0] rect_y;
    logic [DIM_W-1:0] rect_w;
    logic [DIM_W-1:0] rect_h;
  } out_t;

  // effective grid bounds, already clipped to the store
  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } geom_t;

endpackage

/* rtl/core/greedy_rectangle_merge_core.sv */
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_i (grm_pkg::in_t)
// out       output     out_valid_o / out_ready_i  out_o (grm_pkg::out_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A cell write is done in the idle state. A next request walks the cell memory,
// reading each cell visited and then evaluating/updating it, and gives back the
// cells marked in a row that fell short; the cost depends on the grid.
// The 4096-entry cell memory needs no clearing pass; rst_ni clears the cursor.
// One result register sits on the output; a new request is taken while it waits.
`include "greedy_rectangle_merge_core_assert.svh"

module greedy_rectangle_merge_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  grm_pkg::in_t                      in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output grm_pkg::out_t                     out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [grm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [grm_pkg::DIM_W-1:0]         cfg_data_i
);

  localparam int DW = grm_pkg::DIM_W;

  logic [DW-1:0]  grid_w_q, grid_h_q;
  grm_pkg::geom_t geom;
  logic           res_valid, res_ready;
  grm_pkg::out_t  res;
  logic           out_valid_q;
  grm_pkg::out_t  out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= grm_pkg::GRID_RESET;
      grid_h_q <= grm_pkg::GRID_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == grm_pkg::REG_GRID_WIDTH) begin
        grid_w_q <= cfg_data_i;
      end else if (cfg_index_i == grm_pkg::REG_GRID_HEIGHT) begin
        grid_h_q <= cfg_data_i;
      end
    end
  end

  // clip to the store size
  assign geom.cols = (grid_w_q > DW'(grm_pkg::MAX_COLS)) ? DW'(grm_pkg::MAX_COLS) : grid_w_q;
  assign geom.rows = (grid_h_q > DW'(grm_pkg::MAX_ROWS)) ? DW'(grm_pkg::MAX_ROWS) : grid_h_q;

  grm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_i),
    .geom_i      (geom),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  logic rect_nonempty, rect_zero, rect_fits, write_taken;

  assign rect_nonempty = (out_o.rect_w != '0) && (out_o.rect_h != '0);
  assign rect_zero     = (out_o.rect_x == '0) && (out_o.rect_y == '0) &&
                         (out_o.rect_w == '0) && (out_o.rect_h == '0);
  assign rect_fits     = ({1'b0, DW'(out_o.rect_x)} + {1'b0, out_o.rect_w}) <=
                         (DW + 1)'(grm_pkg::MAX_COLS);
  assign write_taken   = in_valid_i && in_ready_o && (in_i.action == grm_pkg::ACT_WRITE);

  `GRM_ASSERT(a_found_nonempty, (out_valid_o && out_o.found) |-> rect_nonempty)
  `GRM_ASSERT(a_done_zero, (out_valid_o && !out_o.found) |-> rect_zero)
  `GRM_ASSERT(a_fits_cols, (out_valid_o && out_o.found) |-> rect_fits)
  `GRM_ASSERT_NEXT(a_write_silent, write_taken && !out_valid_o, !out_valid_o)

endmodule

/* rtl/core/grm_cell_ram.sv */
module grm_cell_ram (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [grm_pkg::ADDR_W-1:0]        waddr_i,
  input  logic [grm_pkg::CELL_W-1:0]        wdata_i,
  input  logic [grm_pkg::ADDR_W-1:0]        raddr_i,
  output logic [grm_pkg::CELL_W-1:0]        rdata_o
);

  logic [grm_pkg::CELL_W-1:0] mem_q [grm_pkg::DEPTH];
  logic [grm_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/grm_seq.sv */
module grm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  grm_pkg::in_t     req_i,
  input  grm_pkg::geom_t   geom_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output grm_pkg::out_t    res_o
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] ST_SCAN_RD  = 4'd1;
  localparam logic [ST_W-1:0] ST_SCAN_EV  = 4'd2;
  localparam logic [ST_W-1:0] ST_RUN_RD   = 4'd3;
  localparam logic [ST_W-1:0] ST_RUN_EV   = 4'd4;
  localparam logic [ST_W-1:0] ST_DOWN_ROW = 4'd5;
  localparam logic [ST_W-1:0] ST_DOWN_RD  = 4'd6;
  localparam logic [ST_W-1:0] ST_DOWN_EV  = 4'd7;
  localparam logic [ST_W-1:0] ST_UNDO     = 4'd8;
  localparam logic [ST_W-1:0] ST_EMIT     = 4'd9;

  localparam int DW = grm_pkg::DIM_W;

  function automatic logic [grm_pkg::ADDR_W-1:0] cell_addr(
    input logic [DW-1:0] cx,
    input logic [DW-1:0] cy
  );
    cell_addr = {cx[grm_pkg::COL_W-1:0], cy[grm_pkg::ROW_W-1:0]};
  endfunction

  logic [ST_W-1:0] state_q, state_d;
  logic [DW-1:0]   x_q, x_d, y_q, y_d;       // scan position / rectangle origin
  logic [DW-1:0]   xe_q, xe_d;               // one past the right edge
  logic [DW-1:0]   yy_q, yy_d;               // row under test
  logic [DW-1:0]   xx_q, xx_d;               // column within tested row
  logic [DW-1:0]   ui_q, ui_d;               // rollback column
  logic [DW-1:0]   h_q, h_d;
  logic [grm_pkg::POS_W-1:0] scan_col_q, scan_col_d;
  logic [grm_pkg::POS_W-1:0] scan_row_q, scan_row_d;
  logic            done_q, done_d;
  grm_pkg::out_t   res_q, res_d;

  logic                         mem_we;
  logic [grm_pkg::ADDR_W-1:0]   mem_waddr;
  logic [grm_pkg::CELL_W-1:0]   mem_wdata;
  logic [grm_pkg::ADDR_W-1:0]   mem_raddr;
  logic [grm_pkg::CELL_W-1:0]   mem_rdata;
  logic                         cell_free;
  logic                         wr_in_range;

  grm_cell_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cell_free   = (mem_rdata == grm_pkg::CELL_FREE);
  assign wr_in_range = (DW'(req_i.cell_x) < DW'(grm_pkg::MAX_COLS)) &&
                       (DW'(req_i.cell_y) < DW'(grm_pkg::MAX_ROWS));

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    xe_d       = xe_q;
    yy_d       = yy_q;
    xx_d       = xx_q;
    ui_d       = ui_q;
    h_d        = h_q;
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    done_d     = done_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = cell_addr(x_q, y_q);
    mem_wdata  = grm_pkg::CELL_TAKEN;
    mem_raddr  = cell_addr(x_q, y_q);

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.action == grm_pkg::ACT_WRITE) begin
            mem_we     = wr_in_range;
            mem_waddr  = cell_addr(DW'(req_i.cell_x), DW'(req_i.cell_y));
            mem_wdata  = {1'b0, req_i.solid};
            scan_col_d = '0;
            scan_row_d = '0;
            done_d     = 1'b0;
          end else if (done_q) begin
            res_d   = '0;
            state_d = ST_EMIT;
          end else begin
            x_d     = DW'(scan_col_q);
            y_d     = DW'(scan_row_q);
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (x_q >= geom_i.cols) begin
          done_d  = 1'b1;
          res_d   = '0;
          state_d = ST_EMIT;
        end else if (y_q >= geom_i.rows) begin
          x_d = x_q + DW'(1);
          y_d = '0;
        end else begin
          state_d = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (cell_free) begin
          mem_we  = 1'b1;
          xe_d    = x_q + DW'(1);
          state_d = ST_RUN_RD;
        end else begin
          y_d     = y_q + DW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_RUN_RD: begin
        mem_raddr = cell_addr(xe_q, y_q);
        if (xe_q >= geom_i.cols) begin
          h_d     = DW'(1);
          yy_d    = y_q + DW'(1);
          state_d = ST_DOWN_ROW;
        end else begin
          state_d = ST_RUN_EV;
        end
      end
      ST_RUN_EV: begin
        mem_waddr = cell_addr(xe_q, y_q);
        if (cell_free) begin
          mem_we  = 1'b1;
          xe_d    = xe_q + DW'(1);
          state_d = ST_RUN_RD;
        end else begin
          h_d     = DW'(1);
          yy_d    = y_q + DW'(1);
          state_d = ST_DOWN_ROW;
        end
      end
      ST_DOWN_ROW: begin
        if (yy_q >= geom_i.rows) begin
          scan_col_d = x_q[grm_pkg::POS_W-1:0];
          scan_row_d = y_q[grm_pkg::POS_W-1:0];
          res_d      = '{found:  1'b1,
                         rect_x: x_q[grm_pkg::POS_W-1:0],
                         rect_y: y_q[grm_pkg::POS_W-1:0],
                         rect_w: xe_q - x_q,
                         rect_h: h_q};
          state_d    = ST_EMIT;
        end else begin
          xx_d    = x_q;
          state_d = ST_DOWN_RD;
        end
      end
      ST_DOWN_RD: begin
        mem_raddr = cell_addr(xx_q, yy_q);
        if (xx_q >= xe_q) begin
          h_d     = h_q + DW'(1);
          yy_d    = yy_q + DW'(1);
          state_d = ST_DOWN_ROW;
        end else begin
          state_d = ST_DOWN_EV;
        end
      end
      ST_DOWN_EV: begin
        mem_waddr = cell_addr(xx_q, yy_q);
        if (cell_free) begin
          mem_we  = 1'b1;
          xx_d    = xx_q + DW'(1);
          state_d = ST_DOWN_RD;
        end else begin
          ui_d    = x_q;
          state_d = ST_UNDO;
        end
      end
      ST_UNDO: begin
        // row fell short: give back the cells marked in it
        mem_waddr = cell_addr(ui_q, yy_q);
        mem_wdata = grm_pkg::CELL_FREE;
        if (ui_q >= xx_q) begin
          scan_col_d = x_q[grm_pkg::POS_W-1:0];
          scan_row_d = y_q[grm_pkg::POS_W-1:0];
          res_d      = '{found:  1'b1,
                         rect_x: x_q[grm_pkg::POS_W-1:0],
                         rect_y: y_q[grm_pkg::POS_W-1:0],
                         rect_w: xe_q - x_q,
                         rect_h: h_q};
          state_d    = ST_EMIT;
        end else begin
          mem_we = 1'b1;
          ui_d   = ui_q + DW'(1);
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_col_q <= '0;
      scan_row_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_col_q <= scan_col_d;
      scan_row_q <= scan_row_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    xe_q  <= xe_d;
    yy_q  <= yy_d;
    xx_q  <= xx_d;
    ui_q  <= ui_d;
    h_q   <= h_d;
    res_q <= res_d;
  end

endmodule
